// ===== src/mpc_pkg.sv =====
// Shared constants, register indexes and control/status types for the
// Mandelbrot pixel colorer. No dependencies.
package mpc_pkg;

	// frame size in pixels
	localparam int Width  = 800;
	localparam int Height = 600;

	// Q4.28 coordinates and iteration count
	localparam int CoordW   = 32;
	localparam int FracBits = 28;
	localparam int IterW    = 12;
	localparam int PosW     = 10;
	localparam int ChanW    = 8;
	localparam int WordW    = 32;

	// coordinate map: span (33 bits signed) times position, divided by frame size
	localparam int SpanW    = CoordW + 1;
	localparam int ProdW    = SpanW + PosW + 1;
	localparam int DivW     = 11;
	localparam int SatInW   = ProdW + 2;

	// division by the frame size: two 22-bit digits, each by reciprocal multiply
	// and one correction step
	localparam int HalfW      = ProdW / 2;
	localparam int RecipShift = 41;
	localparam int QestW      = 2 * CoordW - RecipShift;
	localparam int RemW       = DivW + 1;
	localparam logic [CoordW-1:0] RecipWidth  = CoordW'((64'd1 << RecipShift) / Width);
	localparam logic [CoordW-1:0] RecipHeight = CoordW'((64'd1 << RecipShift) / Height);

	// configuration port
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] RegXMin    = 3'd0;
	localparam logic [CfgIdxW-1:0] RegXMax    = 3'd1;
	localparam logic [CfgIdxW-1:0] RegYMin    = 3'd2;
	localparam logic [CfgIdxW-1:0] RegYMax    = 3'd3;
	localparam logic [CfgIdxW-1:0] RegMaxIter = 3'd4;

	localparam logic signed [CoordW-1:0] XMinRst = -32'sd671088640;
	localparam logic signed [CoordW-1:0] XMaxRst = 32'sd268435456;
	localparam logic signed [CoordW-1:0] YMinRst = -32'sd402653184;
	localparam logic signed [CoordW-1:0] YMaxRst = 32'sd402653184;
	localparam logic [IterW-1:0]         MaxIterRst = 12'd1000;

	typedef struct packed {
		logic accept;      // latch pixel position
		logic sel_y;       // mapping works on the row axis
		logic div_load;    // form product and load the high digit
		logic div_mul;     // register the reciprocal product
		logic div_fix;     // correct the digit, set up the next one
		logic coord_store; // write finished coordinate
		logic z_clear;     // start orbit at zero
		logic mul;         // register the three products
		logic upd;         // advance z and the count
		logic out_load;    // color and load the result register
	} mpc_cmd_t;

	typedef struct packed {
		logic at_limit;
		logic escaped;
	} mpc_sts_t;

endpackage

// ===== src/mpc_if.sv =====
// Valid/ready channel interfaces: pixel input, color result and config write.
// Depends on mpc_pkg.
interface mpc_pix_if;
	import mpc_pkg::*;
	logic            valid;
	logic            ready;
	logic [PosW-1:0] column;
	logic [PosW-1:0] row;
	modport source (output valid, output column, output row, input ready);
	modport sink (input valid, input column, input row, output ready);
endinterface

interface mpc_res_if;
	import mpc_pkg::*;
	logic             valid;
	logic             ready;
	logic [IterW-1:0] iterations;
	logic             inside_res;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;
	logic [WordW-1:0] pixel_word;
	modport source (output valid, output iterations, output inside_res, output red,
		output green, output blue, output pixel_word, input ready);
	modport sink (input valid, input iterations, input inside_res, input red,
		input green, input blue, input pixel_word, output ready);
endinterface

interface mpc_cfg_if;
	import mpc_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CoordW-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/mpc_ctrl.sv =====
// Sequencer for the pixel colorer: coordinate division, orbit loop, result
// handoff. Depends on mpc_pkg.
module mpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  mpc_pkg::mpc_sts_t sts,
	output mpc_pkg::mpc_cmd_t cmd
);
	import mpc_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StLoad   = 3'd1;
	localparam logic [2:0] StDivMul = 3'd2;
	localparam logic [2:0] StDivFix = 3'd3;
	localparam logic [2:0] StStore  = 3'd4;
	localparam logic [2:0] StMul    = 3'd5;
	localparam logic [2:0] StUpd    = 3'd6;
	localparam logic [2:0] StFin    = 3'd7;

	logic [2:0] state_q, state_d;
	logic       axis_q, axis_d;
	logic       half_q, half_d;
	logic       res_valid_q, res_valid_d;

	assign pix_ready = (state_q == StIdle);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		half_d  = half_q;
		cmd     = '0;
		cmd.sel_y = axis_q;
		case (state_q)
			StIdle: begin
				if (pix_valid) begin
					cmd.accept = 1'b1;
					axis_d     = 1'b0;
					state_d    = StLoad;
				end
			end
			StLoad: begin
				cmd.div_load = 1'b1;
				half_d       = 1'b0;
				state_d      = StDivMul;
			end
			StDivMul: begin
				cmd.div_mul = 1'b1;
				state_d     = StDivFix;
			end
			StDivFix: begin
				cmd.div_fix = 1'b1;
				if (half_q) begin
					state_d = StStore;
				end else begin
					half_d  = 1'b1;
					state_d = StDivMul;
				end
			end
			StStore: begin
				cmd.coord_store = 1'b1;
				if (axis_q) begin
					cmd.z_clear = 1'b1;
					state_d     = StMul;
				end else begin
					axis_d  = 1'b1;
					state_d = StLoad;
				end
			end
			StMul: begin
				if (sts.at_limit) begin
					state_d = StFin;
				end else begin
					cmd.mul = 1'b1;
					state_d = StUpd;
				end
			end
			StUpd: begin
				if (sts.escaped) begin
					state_d = StFin;
				end else begin
					cmd.upd = 1'b1;
					state_d = StMul;
				end
			end
			StFin: begin
				// wait for the result register to be free
				if (!res_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_comb begin
		res_valid_d = res_valid_q;
		if (cmd.out_load)
			res_valid_d = 1'b1;
		else if (res_ready)
			res_valid_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			axis_q      <= 1'b0;
			half_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			axis_q      <= axis_d;
			half_q      <= half_d;
			res_valid_q <= res_valid_d;
		end
	end

endmodule

// ===== src/mpc_dp.sv =====
// Datapath for the pixel colorer: view registers, coordinate map with a
// reciprocal divider, z*z+c iteration, hue and result register. Depends on mpc_pkg.
module mpc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [mpc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [mpc_pkg::CoordW-1:0]     cfg_data,
	input  logic [mpc_pkg::PosW-1:0]       pix_column,
	input  logic [mpc_pkg::PosW-1:0]       pix_row,
	input  mpc_pkg::mpc_cmd_t              cmd,
	output mpc_pkg::mpc_sts_t              sts,
	output logic [mpc_pkg::IterW-1:0]      iterations,
	output logic                           inside_res,
	output logic [mpc_pkg::ChanW-1:0]      red,
	output logic [mpc_pkg::ChanW-1:0]      green,
	output logic [mpc_pkg::ChanW-1:0]      blue,
	output logic [mpc_pkg::WordW-1:0]      pixel_word
);
	import mpc_pkg::*;

	localparam int SqW  = 2 * CoordW;
	localparam int MagW = SqW + 1;

	localparam logic [2:0] SecRedYel  = 3'd0;
	localparam logic [2:0] SecYelGrn  = 3'd1;
	localparam logic [2:0] SecGrnCyan = 3'd2;
	localparam logic [2:0] SecCyanBlu = 3'd3;
	localparam logic [2:0] SecBluMag  = 3'd4;

	function automatic logic signed [CoordW-1:0] sat32(input logic signed [SatInW-1:0] v);
		logic hi_ones;
		logic hi_any;
		hi_ones = &v[SatInW-2:CoordW-1];
		hi_any  = |v[SatInW-2:CoordW-1];
		if (v[SatInW-1] && !hi_ones)
			sat32 = {1'b1, {(CoordW-1){1'b0}}};
		else if (!v[SatInW-1] && hi_any)
			sat32 = {1'b0, {(CoordW-1){1'b1}}};
		else
			sat32 = v[CoordW-1:0];
	endfunction

	// view registers
	logic signed [CoordW-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [IterW-1:0]         max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q    <= XMinRst;
			x_max_q    <= XMaxRst;
			y_min_q    <= YMinRst;
			y_max_q    <= YMaxRst;
			max_iter_q <= MaxIterRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegXMin:    x_min_q    <= cfg_data;
				RegXMax:    x_max_q    <= cfg_data;
				RegYMin:    y_min_q    <= cfg_data;
				RegYMax:    y_max_q    <= cfg_data;
				RegMaxIter: max_iter_q <= cfg_data[IterW-1:0];
				default: ;
			endcase
		end
	end

	// pixel position
	logic [PosW-1:0] col_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q <= pix_column;
			row_q <= pix_row;
		end
	end

	// coordinate map: lo + floor(span * pos / size)
	logic signed [CoordW-1:0] lo_sel, hi_sel;
	logic signed [SpanW-1:0]  span;
	logic [PosW-1:0]          pos_sel;
	logic signed [ProdW-1:0]  prod;
	logic [ProdW-1:0]         prod_mag;
	logic [DivW-1:0]          divisor;
	logic [CoordW-1:0]        recip;
	logic [ProdW-1:0]         quo_q;
	logic [DivW-1:0]          rem_q;
	logic                     neg_q;
	logic [HalfW-1:0]         al_q;
	logic [CoordW-1:0]        num_q;
	logic [SqW-1:0]           rprod;
	logic [QestW-1:0]         qe_s1;
	logic [CoordW-1:0]        qd_prod;
	logic [RemW-1:0]          rem_est, rem_new;
	logic                     fix_up;
	logic [QestW-1:0]         dig;
	logic signed [ProdW:0]    quo_pos, quo_floor;
	logic signed [SatInW-1:0] coord_sum;
	logic signed [CoordW-1:0] cr_q, ci_q;

	assign lo_sel   = cmd.sel_y ? y_min_q : x_min_q;
	assign hi_sel   = cmd.sel_y ? y_max_q : x_max_q;
	assign span     = SpanW'(hi_sel) - SpanW'(lo_sel);
	assign pos_sel  = cmd.sel_y ? row_q : col_q;
	assign prod     = ProdW'(span) * ProdW'(signed'({1'b0, pos_sel}));
	assign prod_mag = prod[ProdW-1] ? ProdW'(-prod) : ProdW'(prod);
	assign divisor  = cmd.sel_y ? DivW'(Height) : DivW'(Width);
	assign recip    = cmd.sel_y ? RecipHeight : RecipWidth;

	// estimate is the true digit or one below it; one compare and subtract fixes it
	assign rprod   = SqW'(num_q) * SqW'(recip);
	assign qd_prod = CoordW'(qe_s1) * CoordW'(divisor);
	assign rem_est = num_q[RemW-1:0] - qd_prod[RemW-1:0];
	assign fix_up  = (rem_est >= RemW'(divisor));
	assign rem_new = fix_up ? rem_est - RemW'(divisor) : rem_est;
	assign dig     = qe_s1 + QestW'(fix_up);

	// negative dividend rounds toward minus infinity
	assign quo_pos   = signed'({1'b0, quo_q});
	assign quo_floor = neg_q ? -(quo_pos + (ProdW+1)'(rem_q != '0)) : quo_pos;
	assign coord_sum = SatInW'(lo_sel) + SatInW'(quo_floor);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= CoordW'(prod_mag[ProdW-1:HalfW]);
			al_q  <= prod_mag[HalfW-1:0];
			neg_q <= prod[ProdW-1];
		end else if (cmd.div_fix) begin
			// remainder of the high digit heads the low dividend
			num_q <= {rem_new[CoordW-HalfW-1:0], al_q};
			quo_q <= {quo_q[HalfW-1:0], dig[HalfW-1:0]};
			rem_q <= rem_new[DivW-1:0];
		end
		if (cmd.div_mul)
			qe_s1 <= rprod[SqW-1:RecipShift];
		if (cmd.coord_store) begin
			if (cmd.sel_y)
				ci_q <= sat32(coord_sum);
			else
				cr_q <= sat32(coord_sum);
		end
	end

	// orbit: the three products are registered, then the escape test and update work on them in the next cycle
	logic signed [CoordW-1:0] zr_q, zi_q;
	logic [IterW-1:0]         cnt_q;
	logic signed [SqW-1:0]    sq_re, sq_im, prod_ri;
	logic signed [SqW-1:0]    sr_s1, si_s1, p_s1;
	logic [MagW-1:0]          mag;
	logic signed [MagW-1:0]   diff;
	logic signed [SatInW-1:0] nr, ni;

	assign sq_re   = zr_q * zr_q;
	assign sq_im   = zi_q * zi_q;
	assign prod_ri = zr_q * zi_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			sr_s1 <= sq_re;
			si_s1 <= sq_im;
			p_s1  <= prod_ri;
		end
	end

	assign mag  = {1'b0, sr_s1} + {1'b0, si_s1};
	assign diff = MagW'(sr_s1) - MagW'(si_s1);
	assign nr   = SatInW'(diff >>> FracBits) + SatInW'(cr_q);
	assign ni   = SatInW'(p_s1 >>> (FracBits - 1)) + SatInW'(ci_q);

	assign sts.escaped  = (mag >= (MagW'(4) << (2 * FracBits)));
	assign sts.at_limit = !(cnt_q < max_iter_q);

	always_ff @(posedge clk) begin
		if (cmd.z_clear) begin
			zr_q  <= '0;
			zi_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.upd) begin
			zr_q  <= sat32(nr);
			zi_q  <= sat32(ni);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// six-sector hue from count mod 64
	logic [5:0]       hue_n;
	logic [8:0]       hue_s;
	logic [5:0]       hue_t;
	logic [13:0]      f_full, q_full;
	logic [ChanW-1:0] f255, q255;
	logic [ChanW-1:0] r_c, g_c, b_c;
	logic             in_c;

	assign hue_n  = cnt_q[5:0];
	assign hue_s  = 9'(hue_n) * 9'd6;
	assign hue_t  = hue_s[5:0];
	assign f_full = 14'(hue_t) * 14'd255;
	assign q_full = (14'd64 - 14'(hue_t)) * 14'd255;
	assign f255   = f_full[13:6];
	assign q255   = q_full[13:6];
	assign in_c   = (cnt_q == max_iter_q);

	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		if (!in_c) begin
			case (hue_s[8:6])
				SecRedYel:  begin r_c = 8'hFF; g_c = f255;  b_c = '0;    end
				SecYelGrn:  begin r_c = q255;  g_c = 8'hFF; b_c = '0;    end
				SecGrnCyan: begin r_c = '0;    g_c = 8'hFF; b_c = f255;  end
				SecCyanBlu: begin r_c = '0;    g_c = q255;  b_c = 8'hFF; end
				SecBluMag:  begin r_c = f255;  g_c = '0;    b_c = 8'hFF; end
				default:    begin r_c = 8'hFF; g_c = '0;    b_c = q255;  end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			iterations <= cnt_q;
			inside_res <= in_c;
			red        <= r_c;
			green      <= g_c;
			blue       <= b_c;
			pixel_word <= {8'hFF, b_c, g_c, r_c};
		end
	end

endmodule

// ===== src/mandelbrot_pixel_colorer.sv =====
// Top level of the Mandelbrot pixel colorer: channels, sequencer and datapath.
// Depends on mpc_pkg, mpc_if, mpc_ctrl and mpc_dp.
//
// Takes one pixel (column, row) at a time, maps it onto the view rectangle in
// signed Q4.28, iterates z = z*z + c until |z|^2 reaches 4 or the count hits
// max_iter, and returns the count, the inside flag and an RGBA color. Column
// and row are each mapped in turn (product, then two reciprocal-multiply
// divisions, each a multiply and a correction, then store), and each orbit step
// registers the three 32x32 products and then does the escape test and update.
// The result sits in an output register, so a new pixel is taken as soon as the
// previous one is finished, even if its result has not been collected; a
// finished pixel waits while that register is still full. Config writes are
// always accepted and must only be made while idle.
module mandelbrot_pixel_colorer (
	input  logic     clk,
	input  logic     arst_n,
	mpc_pix_if.sink   pix,
	mpc_res_if.source res,
	mpc_cfg_if.sink   cfg
);
	import mpc_pkg::*;

	mpc_cmd_t cmd;
	mpc_sts_t sts;

	assign cfg.ready = 1'b1;

	mpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.pix_column (pix.column),
		.pix_row    (pix.row),
		.cmd        (cmd),
		.sts        (sts),
		.iterations (res.iterations),
		.inside_res (res.inside_res),
		.red        (res.red),
		.green      (res.green),
		.blue       (res.blue),
		.pixel_word (res.pixel_word)
	);

endmodule
